// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Each macro checks a property on the rising clock edge while reset is released.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge.
`define OTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The consequent holds at the clock edge after the one where the antecedent holds.
`define OTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search package
// Widths, codes and word types shared by the trim search modules.
// ----------------------------------------------------------------------------
package ots_pkg;

	localparam int TRIM_WIDTH      = 8;
	localparam int COUNT_WIDTH     = 20;
	localparam int TARGET_WIDTH    = COUNT_WIDTH + 1;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [TRIM_WIDTH-1:0] TRIM_MAX = {TRIM_WIDTH{1'b1}};

	localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = TARGET_WIDTH'(895);
	localparam logic [TRIM_WIDTH-1:0]   TRIM_RESET   = TRIM_WIDTH'(128);

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_MEASURE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TARGET_COUNT = 1'b0,
		REG_INITIAL_TRIM = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic                   cmd;
		logic [COUNT_WIDTH-1:0] measured_count;
	} cmd_word_t;

	typedef struct packed {
		logic [TRIM_WIDTH-1:0] trim_value;
		logic                  search_done;
		logic                  run_again;
	} res_word_t;

	typedef struct packed {
		logic [TARGET_WIDTH-1:0] target_count;
		logic [TRIM_WIDTH-1:0]   initial_trim;
	} cfg_regs_t;

endpackage

// ===== rtl/ots_cfg.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search configuration registers
// Holds the target count and the initial trim written over the config port.
// ----------------------------------------------------------------------------
module ots_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ots_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ots_pkg::TARGET_WIDTH-1:0]     cfg_data,
	output ots_pkg::cfg_regs_t                   cfg_regs
);

	ots_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_count <= ots_pkg::TARGET_RESET;
			regs_q.initial_trim <= ots_pkg::TRIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (ots_pkg::reg_index_t'(cfg_index))
				ots_pkg::REG_TARGET_COUNT: regs_q.target_count <= cfg_data;
				ots_pkg::REG_INITIAL_TRIM:
					regs_q.initial_trim <= cfg_data[ots_pkg::TRIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/ots_core.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search core
// Input register, search state and the compare-and-update step for one word.
// ----------------------------------------------------------------------------
module ots_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  ots_pkg::cmd_word_t     cmd_word,
	input  ots_pkg::cfg_regs_t     cfg_regs,
	input  logic                   q_full,
	output logic                   push,
	output ots_pkg::res_word_t     push_word
);

	localparam int TW = ots_pkg::TARGET_WIDTH;
	localparam int CW = ots_pkg::COUNT_WIDTH;

	logic                               v_s1;
	ots_pkg::cmd_word_t                 word_s1;

	logic [ots_pkg::TRIM_WIDTH-1:0]     trim_q;
	logic [ots_pkg::TRIM_WIDTH-1:0]     saved_trim_q;
	logic [CW-1:0]                      saved_count_q;
	logic                               was_below_q;
	logic                               was_above_q;
	logic                               done_q;

	logic [ots_pkg::TRIM_WIDTH-1:0]     trim_d;
	logic [ots_pkg::TRIM_WIDTH-1:0]     saved_trim_d;
	logic [CW-1:0]                      saved_count_d;
	logic                               was_below_d;
	logic                               was_above_d;
	logic                               done_d;

	logic [TW-1:0]                      cnt_ext;
	logic [TW-1:0]                      tgt;
	logic                               is_below;
	logic                               is_above;
	logic [TW-1:0]                      err_lo;
	logic [TW-1:0]                      err_hi;
	logic [TW:0]                        saved_minus_tgt;
	logic [TW:0]                        tgt_minus_saved;
	logic                               keep_saved_lo;
	logic                               keep_saved_hi;
	logic                               accept;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = v_s1 && q_full;
	assign push      = v_s1 && !q_full;

	assign cnt_ext  = {1'b0, word_s1.measured_count};
	assign tgt      = cfg_regs.target_count;
	assign is_below = cnt_ext < tgt;
	assign is_above = cnt_ext > tgt;
	assign err_lo   = tgt - cnt_ext;
	assign err_hi   = cnt_ext - tgt;

	// A negative distance to the saved count never wins the comparison.
	assign saved_minus_tgt = {2'b00, saved_count_q} - {1'b0, tgt};
	assign tgt_minus_saved = {1'b0, tgt} - {2'b00, saved_count_q};
	assign keep_saved_lo   = !saved_minus_tgt[TW] && (err_lo > saved_minus_tgt[TW-1:0]);
	assign keep_saved_hi   = !tgt_minus_saved[TW] && (err_hi > tgt_minus_saved[TW-1:0]);

	always_comb begin
		trim_d        = trim_q;
		saved_trim_d  = saved_trim_q;
		saved_count_d = saved_count_q;
		was_below_d   = was_below_q;
		was_above_d   = was_above_q;
		done_d        = done_q;
		if (word_s1.cmd == ots_pkg::CMD_START) begin
			trim_d        = cfg_regs.initial_trim;
			done_d        = 1'b0;
			was_below_d   = 1'b0;
			was_above_d   = 1'b0;
			saved_count_d = '0;
		end else if (!done_q) begin
			if (is_below) begin
				if (was_above_q) begin
					if (keep_saved_lo) begin
						trim_d = saved_trim_q;
					end
					done_d = 1'b1;
				end else if (err_lo == TW'(1)) begin
					done_d = 1'b1;
				end else begin
					saved_trim_d = trim_q;
					if (trim_q != ots_pkg::TRIM_MAX) begin
						trim_d = trim_q + 1'b1;
					end
					was_below_d   = 1'b1;
					saved_count_d = word_s1.measured_count;
				end
			end else if (is_above) begin
				if (was_below_q) begin
					if (keep_saved_hi) begin
						trim_d = saved_trim_q;
					end
					done_d = 1'b1;
				end else if (err_hi == TW'(1)) begin
					done_d = 1'b1;
				end else begin
					saved_trim_d = trim_q;
					if (trim_q != '0) begin
						trim_d = trim_q - 1'b1;
					end
					was_above_d   = 1'b1;
					saved_count_d = word_s1.measured_count;
				end
			end else begin
				done_d = 1'b1;
			end
		end
	end

	assign push_word.trim_value  = trim_d;
	assign push_word.search_done = done_d;
	assign push_word.run_again   = !done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= cmd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q        <= '0;
			saved_trim_q  <= '0;
			saved_count_q <= '0;
			was_below_q   <= 1'b0;
			was_above_q   <= 1'b0;
			done_q        <= 1'b1;
		end else if (push) begin
			trim_q        <= trim_d;
			saved_trim_q  <= saved_trim_d;
			saved_count_q <= saved_count_d;
			was_below_q   <= was_below_d;
			was_above_q   <= was_above_d;
			done_q        <= done_d;
		end
	end

endmodule

// ===== rtl/ots_outq.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search result queue
// Two-entry result buffer that keeps the input side running during a stall.
// ----------------------------------------------------------------------------
module ots_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ots_pkg::res_word_t  push_word,
	output logic                q_full,
	output logic                res_valid,
	input  logic                res_stall,
	output ots_pkg::res_word_t  res_word
);

	ots_pkg::res_word_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               pop;

	assign res_valid = count_q != 2'd0;
	assign q_full    = count_q[1];
	assign pop       = res_valid && !res_stall;
	assign res_word  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/oscillator_trim_search.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search
// Linear auto-trim search for an RC oscillator, one result word per command.
// ----------------------------------------------------------------------------
// A command word either starts a search (the trim loads from initial_trim) or
// delivers the count of one measurement window. Each command word yields one
// result word with the trim to apply, search_done and run_again.
// Command and result channels use valid and stall; a word moves at a clock
// edge with valid high and stall low. The config channel uses valid and ready
// and is always ready; it must be written by the user only while no command
// is in flight, as the block does not enforce this. A command word passes
// from the input register through the single compare-and-update step into
// the result queue, at one word per cycle while the queue is not full.
// A two-entry result queue absorbs receiver stalls; cmd_stall rises only
// when the queue is full and a word waits in the input register.
// Reset clears the queue, loads the config defaults and leaves the search
// done, so counts before the first start word repeat the idle state.
// ----------------------------------------------------------------------------
module oscillator_trim_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  ots_pkg::cmd_word_t                   cmd_word,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output ots_pkg::res_word_t                   res_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ots_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ots_pkg::TARGET_WIDTH-1:0]     cfg_data
);

	ots_pkg::cfg_regs_t cfg_regs;
	ots_pkg::res_word_t push_word;
	logic               push;
	logic               q_full;

	ots_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_regs  (cfg_regs)
	);

	ots_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.cfg_regs  (cfg_regs),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	ots_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.q_full    (q_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

// ===== rtl/ots_checker.sv =====
// ----------------------------------------------------------------------------
// Oscillator trim search checker
// Port-level checks on the trim search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ots_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input ots_pkg::res_word_t res_word
);

	// The input side only stalls when results are waiting.
	`OTS_ASSERT(a_stall_needs_result, clk, arst_n, !cmd_stall || res_valid)

	// The two status bits of a result word always disagree.
	`OTS_ASSERT(a_status_pair, clk, arst_n, !res_valid || (res_word.run_again != res_word.search_done))

	// A stalled result word stays and does not change.
	`OTS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_word))

endmodule

bind oscillator_trim_search ots_checker u_ots_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);
